// File: rtl/core/ofe_pkg.sv
// Package for the off-screen edge indicator: payload types, constants and the divider step.
`default_nettype none
package ofe_pkg;

   // Field widths
   localparam int CoordW   = 16;
   localparam int DimW     = 10;
   localparam int KindW    = 2;
   localparam int CsrIdxW  = 1;

   // Divider geometry: |num| * 256 needs 25 bits, |d| up to 32768 needs 17
   localparam int DvdW       = 25;
   localparam int DvsW       = 17;
   localparam int RemW       = DvsW - 1;
   localparam int DIV_STAGES = DvdW;

   // Register indexes
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_WIDTH  = 1'b0;
   localparam logic [CsrIdxW-1:0] CSR_SCREEN_HEIGHT = 1'b1;

   localparam logic [DimW-1:0] RESET_WIDTH  = 10'd256;
   localparam logic [DimW-1:0] RESET_HEIGHT = 10'd192;

   // Arrow frames
   localparam logic [KindW-1:0] KIND_HORZ = 2'd0;
   localparam logic [KindW-1:0] KIND_VERT = 2'd1;
   localparam logic [KindW-1:0] KIND_DIAG = 2'd2;

   localparam logic [CoordW-1:0] T_START     = 16'h7FFF;
   localparam int                MARKER_SIZE = 8;

   typedef struct packed {
      logic [CoordW-1:0] target_x;
      logic [CoordW-1:0] target_y;
      logic [CoordW-1:0] viewer_x;
      logic [CoordW-1:0] viewer_y;
      logic [CoordW-1:0] camera_x;
      logic [CoordW-1:0] camera_y;
   } req_type;

   typedef struct packed {
      logic [CoordW-1:0] marker_x;
      logic [CoordW-1:0] marker_y;
      logic [KindW-1:0]  arrow_kind;
      logic              flip_horizontal;
      logic              flip_vertical;
   } rsp_type;

   // Per-transaction data that rides alongside the divider
   typedef struct packed {
      logic [CoordW-1:0] cx;
      logic [CoordW-1:0] cy;
      logic [CoordW-1:0] dx;
      logic [CoordW-1:0] dy;
      logic              degen;
      logic              use_x;
      logic              use_y;
      logic              neg_x;
      logic              neg_y;
      logic [KindW-1:0]  kind;
      logic              hflip;
      logic              vflip;
   } side_type;

   // One divider lane: partial remainder, dividend/quotient shifter, divisor
   typedef struct packed {
      logic [RemW-1:0] rem;
      logic [DvdW-1:0] work;
      logic [DvsW-1:0] dvs;
   } div_lane_type;

   // One restoring step: one quotient bit
   function automatic div_lane_type div_step(div_lane_type s);
      logic [DvsW-1:0] trial;
      div_lane_type    r;
      trial  = {s.rem, s.work[DvdW-1]};
      r      = s;
      r.work = {s.work[DvdW-2:0], 1'b0};
      if (trial >= s.dvs) begin
         r.rem     = RemW'(trial - s.dvs);
         r.work[0] = 1'b1;
      end else begin
         r.rem = trial[RemW-1:0];
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/ofe_divider.sv
// Two-lane pipelined restoring divider, one quotient bit per stage, with side data.
`default_nettype none
module ofe_divider (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   advance,
   input  wire                   in_valid,
   input  wire ofe_pkg::div_lane_type in_lane_x,
   input  wire ofe_pkg::div_lane_type in_lane_y,
   input  wire ofe_pkg::side_type     in_side,
   output logic                  out_valid,
   output logic [ofe_pkg::DvdW-1:0] out_quo_x,
   output logic [ofe_pkg::DvdW-1:0] out_quo_y,
   output ofe_pkg::side_type     out_side
);

   logic                  valid_ff  [ofe_pkg::DIV_STAGES];
   ofe_pkg::div_lane_type lane_x_ff [ofe_pkg::DIV_STAGES];
   ofe_pkg::div_lane_type lane_y_ff [ofe_pkg::DIV_STAGES];
   ofe_pkg::side_type     side_ff   [ofe_pkg::DIV_STAGES];

   for (genvar k = 0; k < ofe_pkg::DIV_STAGES; k++) begin : g_stage
      logic                  valid_in;
      ofe_pkg::div_lane_type lane_x_in;
      ofe_pkg::div_lane_type lane_y_in;
      ofe_pkg::side_type     side_in;

      // source: ports for the first stage, previous stage otherwise
      if (k == 0) begin : g_first
         always_comb begin
            valid_in  = in_valid;
            lane_x_in = ofe_pkg::div_step(in_lane_x);
            lane_y_in = ofe_pkg::div_step(in_lane_y);
            side_in   = in_side;
         end
      end else begin : g_next
         always_comb begin
            valid_in  = valid_ff[k-1];
            lane_x_in = ofe_pkg::div_step(lane_x_ff[k-1]);
            lane_y_in = ofe_pkg::div_step(lane_y_ff[k-1]);
            side_in   = side_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= valid_in;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            lane_x_ff[k] <= lane_x_in;
            lane_y_ff[k] <= lane_y_in;
            side_ff[k]   <= side_in;
         end
      end
   end

   assign out_valid = valid_ff[ofe_pkg::DIV_STAGES-1];
   assign out_quo_x = lane_x_ff[ofe_pkg::DIV_STAGES-1].work;
   assign out_quo_y = lane_y_ff[ofe_pkg::DIV_STAGES-1].work;
   assign out_side  = side_ff[ofe_pkg::DIV_STAGES-1];

endmodule
`default_nettype wire

// File: rtl/core/offscreen_edge_indicator.sv
// Off-screen edge indicator: clips a viewer-to-target ray against the screen edges.
// Stages: 1 prep, 25 divider and 5 post stages (T, M, C, B, F) from request to response.
// Throughput: one transaction per cycle unless the response stalls; the two 25-stage divider lanes set the depth.
// A stalled response holds the whole pipeline; no transaction is lost or repeated.
// Reset (synchronous) empties the pipeline and sets the screen to 256 x 192.
`default_nettype none
module offscreen_edge_indicator (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          req_valid,
   output logic                         req_ready,
   input  wire ofe_pkg::req_type        req_payload,
   output logic                         rsp_valid,
   input  wire                          rsp_ready,
   output ofe_pkg::rsp_type             rsp_payload,
   input  wire                          csr_we,
   input  wire [ofe_pkg::CsrIdxW-1:0]   csr_index,
   input  wire [ofe_pkg::DimW-1:0]      csr_wdata
);

   localparam int CW = ofe_pkg::CoordW;

   logic advance;
   logic [ofe_pkg::DimW-1:0] screen_width_ff, screen_height_ff;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         screen_width_ff  <= ofe_pkg::RESET_WIDTH;
         screen_height_ff <= ofe_pkg::RESET_HEIGHT;
      end else if (csr_we) begin
         unique case (csr_index)
            ofe_pkg::CSR_SCREEN_WIDTH:  screen_width_ff  <= csr_wdata;
            ofe_pkg::CSR_SCREEN_HEIGHT: screen_height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ---------------- prep stage: deltas, numerators, slope test
   logic [CW-1:0] cx, cy, dx, dy, adx, ady;
   logic signed [17:0] cx18, cy18, num_x, num_y;
   logic [16:0] mag_x, mag_y;
   logic signed [19:0] ax5, ay5, ax2, ay2;
   ofe_pkg::side_type     side_in;
   ofe_pkg::div_lane_type lane_x_in, lane_y_in;

   always_comb begin
      cx = req_payload.viewer_x - req_payload.camera_x;
      cy = req_payload.viewer_y - req_payload.camera_y;
      dx = req_payload.target_x - req_payload.camera_x - cx;
      dy = req_payload.target_y - req_payload.camera_y - cy;
      cx18 = 18'($signed(cx));
      cy18 = 18'($signed(cy));
      num_x = dx[CW-1] ? -cx18 : $signed({8'b0, screen_width_ff}) - 18'sd1 - cx18;
      num_y = dy[CW-1] ? -cy18 : $signed({8'b0, screen_height_ff}) - 18'sd1 - cy18;
      mag_x = num_x[17] ? 17'(-num_x) : num_x[16:0];
      mag_y = num_y[17] ? 17'(-num_y) : num_y[16:0];

      lane_x_in.rem  = '0;
      lane_x_in.work = {mag_x, 8'b0};
      lane_x_in.dvs  = dx[CW-1] ? 17'(-$signed({dx[CW-1], dx})) : {1'b0, dx};
      lane_y_in.rem  = '0;
      lane_y_in.work = {mag_y, 8'b0};
      lane_y_in.dvs  = dy[CW-1] ? 17'(-$signed({dy[CW-1], dy})) : {1'b0, dy};

      // |d| wraps: the most negative delta stays negative
      adx = dx[CW-1] ? -dx : dx;
      ady = dy[CW-1] ? -dy : dy;
      ax5 = $signed({{4{adx[CW-1]}}, adx}) * 20'sd5;
      ay5 = $signed({{4{ady[CW-1]}}, ady}) * 20'sd5;
      ax2 = $signed({{4{adx[CW-1]}}, adx}) * 20'sd2;
      ay2 = $signed({{4{ady[CW-1]}}, ady}) * 20'sd2;

      side_in.cx    = cx;
      side_in.cy    = cy;
      side_in.dx    = dx;
      side_in.dy    = dy;
      side_in.degen = (dx == '0) && (dy == '0);
      side_in.use_x = (dx != '0);
      side_in.use_y = (dy != '0);
      side_in.neg_x = num_x[17] ^ dx[CW-1];
      side_in.neg_y = num_y[17] ^ dy[CW-1];
      priority if (ay5 < ax2) begin
         side_in.kind  = ofe_pkg::KIND_HORZ;
         side_in.hflip = dx[CW-1];
         side_in.vflip = 1'b0;
      end else if (ax5 < ay2) begin
         side_in.kind  = ofe_pkg::KIND_VERT;
         side_in.hflip = 1'b0;
         side_in.vflip = dy[CW-1];
      end else begin
         side_in.kind  = ofe_pkg::KIND_DIAG;
         side_in.hflip = dx[CW-1];
         side_in.vflip = dy[CW-1];
      end
   end

   logic p_vld_ff;
   ofe_pkg::side_type     p_side_ff;
   ofe_pkg::div_lane_type p_lane_x_ff, p_lane_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
      end else if (advance) begin
         p_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         p_side_ff   <= side_in;
         p_lane_x_ff <= lane_x_in;
         p_lane_y_ff <= lane_y_in;
      end
   end

   // ---------------- divider lanes
   logic d_vld;
   logic [ofe_pkg::DvdW-1:0] quo_x, quo_y;
   ofe_pkg::side_type d_side;

   ofe_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (p_vld_ff),
      .in_lane_x (p_lane_x_ff),
      .in_lane_y (p_lane_y_ff),
      .in_side   (p_side_ff),
      .out_valid (d_vld),
      .out_quo_x (quo_x),
      .out_quo_y (quo_y),
      .out_side  (d_side)
   );

   // ---------------- T stage: signed, wrapped ray parameters
   logic t_vld_ff;
   logic [CW-1:0] t_x_ff, t_y_ff;
   ofe_pkg::side_type t_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_vld_ff <= 1'b0;
      end else if (advance) begin
         t_vld_ff <= d_vld;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t_x_ff    <= d_side.neg_x ? -quo_x[CW-1:0] : quo_x[CW-1:0];
         t_y_ff    <= d_side.neg_y ? -quo_y[CW-1:0] : quo_y[CW-1:0];
         t_side_ff <= d_side;
      end
   end

   // ---------------- M stage: crossing products
   logic m_vld_ff;
   logic [CW-1:0] m_t_x_ff, m_t_y_ff;
   logic signed [31:0] m_prod_x_ff, m_prod_y_ff;
   ofe_pkg::side_type m_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         m_vld_ff <= 1'b0;
      end else if (advance) begin
         m_vld_ff <= t_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         m_t_x_ff    <= t_x_ff;
         m_t_y_ff    <= t_y_ff;
         m_prod_x_ff <= $signed(t_x_ff) * $signed(t_side_ff.dy);
         m_prod_y_ff <= $signed(t_y_ff) * $signed(t_side_ff.dx);
         m_side_ff   <= t_side_ff;
      end
   end

   // ---------------- C stage: edge acceptance, least t
   logic [CW-1:0] c_x, c_y, best1, best;
   logic ok_x, ok_y;

   always_comb begin
      c_x  = m_side_ff.cy + m_prod_x_ff[23:8];
      c_y  = m_side_ff.cx + m_prod_y_ff[23:8];
      ok_x = m_side_ff.use_x && !c_x[CW-1]
             && ($signed({c_x[CW-1], c_x}) < $signed({7'b0, screen_height_ff}))
             && !m_t_x_ff[CW-1] && (m_t_x_ff != ofe_pkg::T_START);
      best1 = ok_x ? m_t_x_ff : ofe_pkg::T_START;
      ok_y = m_side_ff.use_y && !c_y[CW-1]
             && ($signed({c_y[CW-1], c_y}) < $signed({7'b0, screen_width_ff}))
             && !m_t_y_ff[CW-1] && ($signed(m_t_y_ff) < $signed(best1));
      best = ok_y ? m_t_y_ff : best1;
   end

   logic c_vld_ff;
   logic [CW-1:0] c_best_ff;
   ofe_pkg::side_type c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_vld_ff <= 1'b0;
      end else if (advance) begin
         c_vld_ff <= m_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         c_best_ff <= best;
         c_side_ff <= m_side_ff;
      end
   end

   // ---------------- B stage: marker products
   logic b_vld_ff;
   logic signed [31:0] b_prod_x_ff, b_prod_y_ff;
   ofe_pkg::side_type b_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_vld_ff <= 1'b0;
      end else if (advance) begin
         b_vld_ff <= c_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_prod_x_ff <= $signed(c_best_ff) * $signed(c_side_ff.dx);
         b_prod_y_ff <= $signed(c_best_ff) * $signed(c_side_ff.dy);
         b_side_ff   <= c_side_ff;
      end
   end

   // ---------------- F stage: clamp and response register
   logic [CW-1:0] mx0, my0, mx1, my1, mx2, my2;
   logic signed [16:0] w_lim, h_lim;
   ofe_pkg::rsp_type rsp_in;

   always_comb begin
      mx0   = b_side_ff.cx + b_prod_x_ff[23:8];
      my0   = b_side_ff.cy + b_prod_y_ff[23:8];
      w_lim = $signed({7'b0, screen_width_ff})
              - 17'(ofe_pkg::MARKER_SIZE);
      h_lim = $signed({7'b0, screen_height_ff})
              - 17'(ofe_pkg::MARKER_SIZE);
      mx1 = mx0[CW-1] ? '0 : mx0;
      my1 = my0[CW-1] ? '0 : my0;
      mx2 = ($signed({mx1[CW-1], mx1}) >= w_lim) ? CW'(w_lim - 17'sd1) : mx1;
      my2 = ($signed({my1[CW-1], my1}) >= h_lim) ? CW'(h_lim - 17'sd1) : my1;
      if (b_side_ff.degen) begin
         rsp_in.marker_x        = b_side_ff.cx;
         rsp_in.marker_y        = b_side_ff.cy;
         rsp_in.arrow_kind      = ofe_pkg::KIND_DIAG;
         rsp_in.flip_horizontal = 1'b0;
         rsp_in.flip_vertical   = 1'b0;
      end else begin
         rsp_in.marker_x        = mx2;
         rsp_in.marker_y        = my2;
         rsp_in.arrow_kind      = b_side_ff.kind;
         rsp_in.flip_horizontal = b_side_ff.hflip;
         rsp_in.flip_vertical   = b_side_ff.vflip;
      end
   end

   logic rsp_valid_ff;
   ofe_pkg::rsp_type rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= b_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

`ifndef ASSERT_OFF
   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.arrow_kind == ofe_pkg::KIND_HORZ
                     || rsp_payload.arrow_kind == ofe_pkg::KIND_VERT
                     || rsp_payload.arrow_kind == ofe_pkg::KIND_DIAG))
      else $error("illegal arrow frame");

   a_horz_no_vflip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.arrow_kind == ofe_pkg::KIND_HORZ)
      |-> !rsp_payload.flip_vertical)
      else $error("horizontal frame with vertical flip");

   a_vert_no_hflip: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_payload.arrow_kind == ofe_pkg::KIND_VERT)
      |-> !rsp_payload.flip_horizontal)
      else $error("vertical frame with horizontal flip");
`endif

endmodule
`default_nettype wire

// File: tb/testbench.sv
// Testbench for the off-screen edge indicator: directed and random positions, scoreboard check.
`default_nettype none

// Scoreboard: predicts the indicator result for each accepted position and checks responses.
class edge_marker_board;
   ofe_pkg::rsp_type pending_markers[$];
   int unsigned      mismatch_count;
   int signed        scr_w;
   int signed        scr_h;

   function new();
      mismatch_count = 0;
      scr_w = 256;
      scr_h = 192;
   endfunction

   // Arithmetic (floor) shift by 8
   static function int signed shr8(int signed v);
      return v >>> 8;
   endfunction

   static function int signed w16(int signed v);
      return int'($signed(v[15:0]));
   endfunction

   // Work out the expected marker for one position
   function ofe_pkg::rsp_type predict_marker(ofe_pkg::req_type r);
      ofe_pkg::rsp_type m;
      int signed cx, cy, dx, dy, best, t, c, num, mx, my, adx, ady;
      cx = w16(int'($signed(r.viewer_x)) - int'($signed(r.camera_x)));
      cy = w16(int'($signed(r.viewer_y)) - int'($signed(r.camera_y)));
      dx = w16(int'($signed(r.target_x)) - int'($signed(r.camera_x)) - cx);
      dy = w16(int'($signed(r.target_y)) - int'($signed(r.camera_y)) - cy);
      m = '0;
      if (dx == 0 && dy == 0) begin
         m.marker_x = cx[15:0];
         m.marker_y = cy[15:0];
         m.arrow_kind = ofe_pkg::KIND_DIAG;
         return m;
      end
      best = 32'h7FFF;
      if (dx != 0) begin
         num = (dx < 0) ? -cx : (scr_w - 1 - cx);
         t = w16((num * 256) / dx);
         c = w16(cy + shr8(t * dy));
         if (c >= 0 && c < scr_h && t >= 0 && t < best) best = t;
      end
      if (dy != 0) begin
         num = (dy < 0) ? -cy : (scr_h - 1 - cy);
         t = w16((num * 256) / dy);
         c = w16(cx + shr8(t * dx));
         if (c >= 0 && c < scr_w && t >= 0 && t < best) best = t;
      end
      mx = w16(cx + shr8(best * dx));
      my = w16(cy + shr8(best * dy));
      if (mx < 0) mx = 0;
      if (mx >= scr_w - 8) mx = scr_w - 9;
      if (my < 0) my = 0;
      if (my >= scr_h - 8) my = scr_h - 9;
      adx = w16(dx < 0 ? -dx : dx);
      ady = w16(dy < 0 ? -dy : dy);
      m.marker_x = mx[15:0];
      m.marker_y = my[15:0];
      if (ady * 5 < adx * 2) begin
         m.arrow_kind = ofe_pkg::KIND_HORZ;
         m.flip_horizontal = dx < 0;
      end else if (adx * 5 < ady * 2) begin
         m.arrow_kind = ofe_pkg::KIND_VERT;
         m.flip_vertical = dy < 0;
      end else begin
         m.arrow_kind = ofe_pkg::KIND_DIAG;
         m.flip_horizontal = dx < 0;
         m.flip_vertical = dy < 0;
      end
      return m;
   endfunction

   function void note_position(ofe_pkg::req_type r);
      pending_markers.push_back(predict_marker(r));
   endfunction

   task report(string what, int unsigned got, int unsigned want);
      $display("mismatch %s: got %0h expected %0h", what, got, want);
      mismatch_count++;
   endtask

   task check_marker(ofe_pkg::rsp_type g);
      ofe_pkg::rsp_type e;
      if (pending_markers.size() == 0) begin
         report("unexpected transaction", g, 0);
         return;
      end
      e = pending_markers.pop_front();
      if (g.marker_x !== e.marker_x) report("marker_x", g.marker_x, e.marker_x);
      if (g.marker_y !== e.marker_y) report("marker_y", g.marker_y, e.marker_y);
      if (g.arrow_kind !== e.arrow_kind) report("arrow_kind", g.arrow_kind, e.arrow_kind);
      if (g.flip_horizontal !== e.flip_horizontal)
         report("flip_horizontal", g.flip_horizontal, e.flip_horizontal);
      if (g.flip_vertical !== e.flip_vertical)
         report("flip_vertical", g.flip_vertical, e.flip_vertical);
   endtask
endclass

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LATENCY = 31;
   localparam int STALL_LIMIT = 5000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   ofe_pkg::req_type req_payload = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   ofe_pkg::rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [ofe_pkg::CsrIdxW-1:0] csr_index = ofe_pkg::CSR_SCREEN_WIDTH;
   logic [ofe_pkg::DimW-1:0] csr_wdata = '0;

   edge_marker_board board = new();
   int unsigned idle_cycles = 0;
   int unsigned stall_phase = 0;

   offscreen_edge_indicator dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Response side: stall pattern, check accepted transactions, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) board.check_marker(rsp_payload);
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > STALL_LIMIT) begin
            $display("Mismatches found");
            $finish;
         end
      end
      stall_phase <= stall_phase + 1;
      case ((stall_phase / 200) % 3)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= (stall_phase % 7) < 3;
      endcase
   end

   task automatic send_position(ofe_pkg::req_type r);
      req_valid <= 1'b1;
      req_payload <= r;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_position(r);
   endtask

   task automatic pause_sender(int unsigned n);
      req_valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic drain_markers();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending_markers.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_screen(logic [ofe_pkg::DimW-1:0] w, logic [ofe_pkg::DimW-1:0] h);
      csr_we <= 1'b1;
      csr_index <= ofe_pkg::CSR_SCREEN_WIDTH;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= ofe_pkg::CSR_SCREEN_HEIGHT;
      csr_wdata <= h;
      @(posedge clock);
      csr_we <= 1'b0;
      board.scr_w = w;
      board.scr_h = h;
   endtask

   function automatic logic [15:0] rand_coord();
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: return 16'($urandom_range(0, 600));
         2: return 16'($urandom_range(0, 64) - 32);
         default: return ($urandom_range(0, 1)) ? 16'h8000 : 16'h7FFF;
      endcase
   endfunction

   // Mostly viewer on screen and target nearby, sometimes anything
   function automatic ofe_pkg::req_type rand_position();
      ofe_pkg::req_type r;
      r.camera_x = rand_coord();
      r.camera_y = rand_coord();
      if ($urandom_range(0, 3) != 0) begin
         r.viewer_x = r.camera_x + 16'($urandom_range(0, board.scr_w + 8));
         r.viewer_y = r.camera_y + 16'($urandom_range(0, board.scr_h + 8));
         r.target_x = r.viewer_x + 16'($urandom_range(0, 2000) - 1000);
         r.target_y = r.viewer_y + 16'($urandom_range(0, 2000) - 1000);
         if ($urandom_range(0, 15) == 0) r.target_x = r.viewer_x;
         if ($urandom_range(0, 15) == 0) r.target_y = r.viewer_y;
      end else begin
         r.viewer_x = rand_coord();
         r.viewer_y = rand_coord();
         r.target_x = rand_coord();
         r.target_y = rand_coord();
      end
      return r;
   endfunction

   task automatic random_phase(int unsigned n);
      int unsigned burst;
      while (n > 0) begin
         burst = $urandom_range(1, 40);
         while (burst > 0 && n > 0) begin
            send_position(rand_position());
            burst--;
            n--;
         end
         if ($urandom_range(0, 2) != 0) pause_sender($urandom_range(1, 12));
      end
   endtask

   initial begin
      ofe_pkg::req_type r;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: coincident points, extremes, axis and diagonal rays
      r = '0;
      send_position(r);
      r = '{16'h8000, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000};
      send_position(r);
      r = '{16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF};
      send_position(r);
      r = '{16'd1000, 16'd96, 16'd128, 16'd96, 16'd0, 16'd0};
      send_position(r);
      r = '{-16'sd1000, 16'd96, 16'd128, 16'd96, 16'd0, 16'd0};
      send_position(r);
      r = '{16'd128, 16'd900, 16'd128, 16'd96, 16'd0, 16'd0};
      send_position(r);
      r = '{16'd128, -16'sd900, 16'd128, 16'd96, 16'd0, 16'd0};
      send_position(r);
      r = '{16'd900, 16'd900, 16'd128, 16'd96, 16'd0, 16'd0};
      send_position(r);
      r = '{-16'sd500, -16'sd500, 16'd128, 16'd96, 16'd0, 16'd0};
      send_position(r);
      r = '{16'd2000, 16'd50, 16'd5000, 16'd5000, 16'd0, 16'd0};
      send_position(r);
      r = '{16'h8000, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0};
      send_position(r);
      r = '{16'd0, 16'h8000, 16'd0, 16'd0, 16'd0, 16'd0};
      send_position(r);
      r = '{16'd5, 16'd2, 16'd0, 16'd0, 16'd0, 16'd0};
      send_position(r);
      r = '{16'd2, 16'd5, 16'd0, 16'd0, 16'd0, 16'd0};
      send_position(r);
      r = '{16'd40, 16'd50, 16'd30, 16'd40, 16'd20, 16'd30};
      send_position(r);
      drain_markers();

      // Settings: reset default, extremes, tiny and out-of-range values
      random_phase(250);
      drain_markers();
      write_screen(10'd16, 10'd16);
      random_phase(200);
      drain_markers();
      write_screen(10'd512, 10'd512);
      random_phase(200);
      drain_markers();
      write_screen(10'd4, 10'd1023);
      random_phase(150);
      drain_markers();
      write_screen(10'd0, 10'd8);
      random_phase(100);
      drain_markers();
      write_screen(10'd320, 10'd240);
      random_phase(150);
      drain_markers();

      if (board.mismatch_count == 0 && board.pending_markers.size() == 0) begin
         $display("No mismatches found");
      end else begin
         if (board.pending_markers.size() != 0)
            $display("%0d expected transactions never arrived",
                     board.pending_markers.size());
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

`default_nettype wire
